// ===== design/fpe_pkg.sv =====
`default_nettype none
package fpe_pkg;

  localparam int MEM_WORDS = 1048576;
  localparam int MAX_DIM   = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);

  localparam int DIM_W   = 13;
  localparam int PITCH_W = 14;
  localparam int POS_W   = 16;
  localparam int PIX_W   = 32;
  localparam int PROD_W  = DIM_W + PITCH_W;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [PIX_W-1:0]   pixel_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [PITCH_W-1:0] pitch_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [1:0]         opcode_t;
  typedef logic [1:0]         status_t;
  typedef logic [1:0]         reg_index_t;

  localparam opcode_t OP_WRITE  = 2'd0;
  localparam opcode_t OP_READ   = 2'd1;
  localparam opcode_t OP_FILL   = 2'd2;
  localparam opcode_t OP_SCROLL = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOT_INIT = 2'd1;
  localparam status_t ST_BOUNDS   = 2'd2;
  localparam status_t ST_GEOMETRY = 2'd3;

  localparam reg_index_t REG_ENABLED = 2'd0;
  localparam reg_index_t REG_WIDTH   = 2'd1;
  localparam reg_index_t REG_HEIGHT  = 2'd2;
  localparam reg_index_t REG_PITCH   = 2'd3;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    pixel_t data;
  } wr_req_t;

endpackage
`default_nettype wire

// ===== design/fpe_if.sv =====
`default_nettype none
interface fpe_cmd_if import fpe_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  pos_t    pos_x;
  pos_t    pos_y;
  pixel_t  pixel_value;
  pos_t    scroll_rows;

  modport source (output valid, opcode, pos_x, pos_y, pixel_value, scroll_rows,
                  input ready);
  modport sink (input valid, opcode, pos_x, pos_y, pixel_value, scroll_rows,
                output ready);
endinterface

interface fpe_rsp_if import fpe_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  pixel_t  read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink (input valid, status, read_data, output ready);
endinterface
`default_nettype wire

// ===== design/fpe_ram.sv =====
`default_nettype none
module fpe_ram import fpe_pkg::*; (
  input  wire logic    clk,
  input  wire wr_req_t wr,
  input  wire addr_t   raddr,
  output pixel_t       rdata
);

  pixel_t mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/framebuffer_pixel_engine.sv =====
// Pixel write: check, memory access, result. Read: check, access, read wait, result.
// Refusal: check, result. Fill: check, paint of the whole frame, one pixel written per
// cycle, result. Scroll up by n (0 < n < height): copy of the lower height - n rows,
// a drain step, paint of the bottom n rows, result; a zero scroll goes check, result.
// One item in work at a time; the next beat is taken the cycle after the result
// register loads, and a stalled result holds it off. Reset clears config and control.
`default_nettype none
module framebuffer_pixel_engine import fpe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire reg_index_t cfg_index,
  input  wire pitch_t     cfg_wdata,
  fpe_cmd_if.sink         cmd,
  fpe_rsp_if.source       rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_RDW   = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_PAINT = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0] state;

  logic   enabled;
  dim_t   frame_width;
  dim_t   frame_height;
  pitch_t row_pitch;

  opcode_t op;
  pos_t    px;
  pos_t    py;
  pixel_t  colour;
  pos_t    rows;

  addr_t addr;
  addr_t src_base;
  addr_t dst_base;
  dim_t  x;
  dim_t  y;
  dim_t  copy_end;

  logic  pend_valid;
  addr_t pend_addr;

  status_t res_status;
  pixel_t  res_data;
  logic    out_valid;
  status_t out_status;
  pixel_t  out_data;

  logic [PROD_W-1:0] geo_prod;
  logic              geo_ok;
  dim_t              mul_a;
  logic [PROD_W-1:0] prod;
  logic              last_x;

  wr_req_t wr;
  addr_t   raddr;
  pixel_t  rdata;

  fpe_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign geo_prod = PROD_W'(row_pitch) * PROD_W'(frame_height);
  assign geo_ok = (frame_width != '0) && (frame_height != '0) &&
                  (32'(frame_width) <= 32'(MAX_DIM)) &&
                  (32'(frame_height) <= 32'(MAX_DIM)) &&
                  (row_pitch >= PITCH_W'(frame_width)) &&
                  (32'(geo_prod) <= 32'(MEM_WORDS));

  // one multiplier serves the pixel address and the scroll source offset
  assign mul_a  = (op == OP_SCROLL) ? rows[DIM_W-1:0] : py[DIM_W-1:0];
  assign prod   = PROD_W'(mul_a) * PROD_W'(row_pitch);
  assign last_x = (x == frame_width - 1'b1);

  assign cmd.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.read_data = out_data;

  always_comb begin
    wr    = '0;
    raddr = addr;
    case (state)
      S_ACC: begin
        if (op == OP_WRITE) begin
          wr = '{en: 1'b1, addr: addr, data: colour};
        end
      end
      S_COPY: raddr = src_base + ADDR_W'(x);
      S_PAINT: wr = '{en: 1'b1, addr: dst_base + ADDR_W'(x), data: colour};
      default: ;
    endcase
    // copy write lands in the cycle after its read
    if (pend_valid) begin
      wr = '{en: 1'b1, addr: pend_addr, data: rdata};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      enabled      <= 1'b0;
      frame_width  <= '0;
      frame_height <= '0;
      row_pitch    <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLED: enabled      <= cfg_wdata[0];
          REG_WIDTH:   frame_width  <= cfg_wdata[DIM_W-1:0];
          REG_HEIGHT:  frame_height <= cfg_wdata[DIM_W-1:0];
          REG_PITCH:   row_pitch    <= cfg_wdata;
          default: ;
        endcase
      end

      pend_valid <= (state == S_COPY);
      pend_addr  <= dst_base + ADDR_W'(x);

      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op     <= cmd.opcode;
            px     <= cmd.pos_x;
            py     <= cmd.pos_y;
            colour <= cmd.pixel_value;
            rows   <= cmd.scroll_rows;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_status <= ST_OK;
          res_data   <= '0;
          x          <= '0;
          y          <= '0;
          dst_base   <= '0;
          src_base   <= prod[ADDR_W-1:0];
          copy_end   <= frame_height - rows[DIM_W-1:0];
          addr       <= prod[ADDR_W-1:0] + ADDR_W'(px);
          if (!enabled) begin
            res_status <= ST_NOT_INIT;
            state      <= S_RESP;
          end else if (!geo_ok) begin
            res_status <= ST_GEOMETRY;
            state      <= S_RESP;
          end else begin
            case (op) inside
              OP_WRITE, OP_READ: begin
                if (px >= POS_W'(frame_width) || py >= POS_W'(frame_height)) begin
                  res_status <= ST_BOUNDS;
                  state      <= S_RESP;
                end else begin
                  state <= S_ACC;
                end
              end
              OP_FILL: state <= S_PAINT;
              default: begin
                if (rows == '0) begin
                  state <= S_RESP;
                end else if (rows >= POS_W'(frame_height)) begin
                  state <= S_PAINT;
                end else begin
                  state <= S_COPY;
                end
              end
            endcase
          end
        end
        S_ACC: state <= (op == OP_WRITE) ? S_RESP : S_RDW;
        S_RDW: begin
          res_data <= rdata;
          state    <= S_RESP;
        end
        S_COPY: begin
          x <= x + 1'b1;
          if (last_x) begin
            x        <= '0;
            y        <= y + 1'b1;
            dst_base <= dst_base + ADDR_W'(row_pitch);
            src_base <= src_base + ADDR_W'(row_pitch);
            if (y == copy_end - 1'b1) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: state <= S_PAINT;
        S_PAINT: begin
          x <= x + 1'b1;
          if (last_x) begin
            x        <= '0;
            y        <= y + 1'b1;
            dst_base <= dst_base + ADDR_W'(row_pitch);
            if (y == frame_height - 1'b1) begin
              state <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_data   <= res_data;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_framebuffer_pixel_engine.sv =====
`timescale 1ns / 1ps
module tb_framebuffer_pixel_engine;
  import fpe_pkg::*;

  localparam int LIMIT_CYCLES    = 1000000;
  localparam int RAND_PHASES     = 9;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_AT_RESULT  = 150;
  localparam int HOLD_CYCLES     = 400;
  localparam int END_DRAIN       = 32;

  typedef struct {
    opcode_t opcode;
    pos_t    pos_x;
    pos_t    pos_y;
    pixel_t  pixel_value;
    pos_t    scroll_rows;
  } pixel_op_t;

  typedef struct {
    status_t status;
    pixel_t  read_data;
  } op_result_t;

  // Tracks registers and the written part of the frame memory; words never
  // written (or copied from unwritten words) are absent from the map.
  class frame_tracker;
    bit           enabled;
    dim_t         width;
    dim_t         height;
    pitch_t       pitch;
    pixel_t       frame [int unsigned];
    op_result_t   pending_results [$];
    int           errors;

    function void set_reg(reg_index_t idx, pitch_t val);
      case (idx)
        REG_ENABLED: enabled = val[0];
        REG_WIDTH:   width = val[DIM_W-1:0];
        REG_HEIGHT:  height = val[DIM_W-1:0];
        REG_PITCH:   pitch = val;
        default: ;
      endcase
    endfunction

    function bit geometry_ok();
      if (width == 0 || height == 0) return 1'b0;
      if (width > MAX_DIM || height > MAX_DIM) return 1'b0;
      if (pitch < width) return 1'b0;
      if (longint'(pitch) * longint'(height) > longint'(MEM_WORDS)) return 1'b0;
      return 1'b1;
    endfunction

    function int unsigned addr_of(int unsigned x, int unsigned y);
      return y * pitch + x;
    endfunction

    function bit is_written(int unsigned x, int unsigned y);
      return frame.exists(addr_of(x, y));
    endfunction

    function void paint_rows(int unsigned first, pixel_t colour);
      for (int unsigned y = first; y < height; y++)
        for (int unsigned x = 0; x < width; x++)
          frame[addr_of(x, y)] = colour;
    endfunction

    function void scroll_up(int unsigned rows, pixel_t colour);
      int unsigned src;
      int unsigned dst;
      if (rows == 0) return;
      if (rows >= height) begin
        paint_rows(0, colour);
        return;
      end
      for (int unsigned y = 0; y + rows < height; y++)
        for (int unsigned x = 0; x < width; x++) begin
          dst = addr_of(x, y);
          src = addr_of(x, y + rows);
          if (frame.exists(src)) frame[dst] = frame[src];
          else frame.delete(dst);
        end
      paint_rows(height - rows, colour);
    endfunction

    function void note_command(pixel_op_t c);
      op_result_t  r;
      int unsigned a;
      r.status = ST_OK;
      r.read_data = '0;
      if (!enabled) begin
        r.status = ST_NOT_INIT;
      end else if (!geometry_ok()) begin
        r.status = ST_GEOMETRY;
      end else if (c.opcode == OP_WRITE || c.opcode == OP_READ) begin
        a = addr_of(c.pos_x, c.pos_y);
        if (c.pos_x >= width || c.pos_y >= height) r.status = ST_BOUNDS;
        else if (c.opcode == OP_WRITE) frame[a] = c.pixel_value;
        else if (frame.exists(a)) r.read_data = frame[a];
      end else if (c.opcode == OP_FILL) begin
        paint_rows(0, c.pixel_value);
      end else begin
        scroll_up(c.scroll_rows, c.pixel_value);
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(status_t st, pixel_t data);
      op_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual status %0d data %h",
                 $time, st, data);
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d actual %0d", $time, e.status, st);
      end
      if (data !== e.read_data) begin
        errors++;
        $display("%0t: read_data mismatch, expected %h actual %h", $time, e.read_data, data);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  reg_index_t cfg_index;
  pitch_t     cfg_wdata;

  fpe_cmd_if cmd_bus ();
  fpe_rsp_if rsp_bus ();

  framebuffer_pixel_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_bus),
    .rsp       (rsp_bus)
  );

  always #5 clk = ~clk;

  frame_tracker sb = new();
  int cmd_burst = 0;
  int rsp_burst = 0;
  int cycle_count = 0;

  // Random wait per beat, with occasional runs of back-to-back beats.
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      burst_left = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic pixel_op_t random_op();
    pixel_op_t c;
    c.opcode = opcode_t'($urandom_range(0, 3));
    c.pos_x = pos_t'($urandom_range(0, 65535));
    c.pos_y = pos_t'($urandom_range(0, 65535));
    c.pixel_value = $urandom;
    c.scroll_rows = pos_t'($urandom_range(0, 65535));
    return c;
  endfunction

  task automatic send_cmd(pixel_op_t c);
    int gap;
    gap = draw_wait(cmd_burst);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.opcode      <= c.opcode;
    cmd_bus.pos_x       <= c.pos_x;
    cmd_bus.pos_y       <= c.pos_y;
    cmd_bus.pixel_value <= c.pixel_value;
    cmd_bus.scroll_rows <= c.scroll_rows;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    sb.note_command(c);
  endtask

  task automatic send_op(opcode_t op, int x, int y, pixel_t v, int rows);
    pixel_op_t c;
    c.opcode = op;
    c.pos_x = pos_t'(x);
    c.pos_y = pos_t'(y);
    c.pixel_value = v;
    c.scroll_rows = pos_t'(rows);
    send_cmd(c);
  endtask

  // Drop valid, let every result come back, then program all four registers.
  task automatic next_setting(pitch_t en_v, pitch_t w_v, pitch_t h_v, pitch_t p_v);
    reg_index_t idx [4];
    pitch_t     vals [4];
    idx = '{REG_ENABLED, REG_WIDTH, REG_HEIGHT, REG_PITCH};
    vals = '{en_v, w_v, h_v, p_v};
    cmd_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_any_items(int count);
    for (int i = 0; i < count; i++) send_cmd(random_op());
  endtask

  task automatic run_valid_items(int count);
    pixel_op_t c;
    int        pick;
    int        w;
    int        h;
    w = sb.width;
    h = sb.height;
    if ($urandom_range(0, 3) != 0) begin
      c = random_op();
      c.opcode = OP_FILL;
      send_cmd(c);
    end
    for (int i = 0; i < count; i++) begin
      c = random_op();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        c.pos_x = pos_t'($urandom_range(0, w - 1));
        c.pos_y = pos_t'($urandom_range(0, h - 1));
        c.opcode = (pick < 40) ? OP_WRITE : OP_READ;
        if (c.opcode == OP_READ && !sb.is_written(c.pos_x, c.pos_y)) c.opcode = OP_WRITE;
      end else if (pick < 78) begin
        c.opcode = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        if ($urandom_range(0, 1)) c.pos_x = pos_t'($urandom_range(w, 65535));
        else c.pos_y = pos_t'($urandom_range(h, 65535));
      end else if (pick < 85) begin
        c.opcode = OP_FILL;
      end else begin
        c.opcode = OP_SCROLL;
        pick = $urandom_range(0, 99);
        if (pick < 10) c.scroll_rows = '0;
        else if (pick < 70) c.scroll_rows = pos_t'((h > 1) ? $urandom_range(1, h - 1) : 1);
        else if (pick < 85) c.scroll_rows = pos_t'($urandom_range(h, h + 4));
      end
      send_cmd(c);
    end
  endtask

  task automatic valid_setting();
    int w;
    int h;
    int p;
    if ($urandom_range(0, 5) == 0) begin
      w = $urandom_range(200, 400);
      h = $urandom_range(1, 2);
    end else begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 16);
    end
    p = ($urandom_range(0, 3) == 0) ? w : w + $urandom_range(1, 16);
    next_setting(pitch_t'($urandom_range(0, 8191) * 2 + 1), pitch_t'(w), pitch_t'(h),
                 pitch_t'(p));
  endtask

  task automatic bad_setting();
    int w;
    int h;
    int p;
    w = $urandom_range(1, 16);
    h = $urandom_range(1, 16);
    p = $urandom_range(16, 16383);
    case ($urandom_range(0, 5))
      0: w = 0;
      1: h = 0;
      2: w = $urandom_range(MAX_DIM + 1, 8191);
      3: h = $urandom_range(MAX_DIM + 1, 8191);
      4: begin
        w = $urandom_range(2, 16);
        p = $urandom_range(0, w - 1);
      end
      default: begin
        p = $urandom_range(8192, 16383);
        h = $urandom_range(MEM_WORDS / p + 1, MAX_DIM);
      end
    endcase
    next_setting(pitch_t'(1), pitch_t'(w), pitch_t'(h), pitch_t'(p));
  endtask

  // Result side: random stall per beat, one long hold-off to back up the block.
  initial begin
    int results_seen;
    int stall;
    results_seen = 0;
    rsp_bus.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (results_seen == HOLD_AT_RESULT) stall = HOLD_CYCLES;
      else stall = draw_wait(rsp_burst);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (rsp_bus.valid !== 1'b1);
      sb.check_result(rsp_bus.status, rsp_bus.read_data);
      results_seen++;
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("framebuffer_pixel_engine verification failed");
    $finish;
  end

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_ENABLED;
    cfg_wdata           <= '0;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.opcode      <= OP_WRITE;
    cmd_bus.pos_x       <= '0;
    cmd_bus.pos_y       <= '0;
    cmd_bus.pixel_value <= '0;
    cmd_bus.scroll_rows <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // out of reset: everything refused as not initialized
    send_op(OP_WRITE, 0, 0, 32'h1234_5678, 0);
    send_op(OP_READ, 0, 0, 32'h0, 0);
    send_op(OP_FILL, 0, 0, 32'hdead_beef, 0);
    send_op(OP_SCROLL, 0, 0, 32'h0, 1);

    // bad geometry: zero width, width over MAX_DIM, pitch below width, frame too big
    next_setting(pitch_t'(1), pitch_t'(0), pitch_t'(4), pitch_t'(4));
    send_op(OP_WRITE, 0, 0, 32'h1, 0);
    next_setting(pitch_t'(16383), pitch_t'(8191), pitch_t'(1), pitch_t'(16383));
    send_op(OP_READ, 0, 0, 32'h0, 0);
    next_setting(pitch_t'(1), pitch_t'(4), pitch_t'(4), pitch_t'(3));
    send_op(OP_FILL, 0, 0, 32'h5, 0);
    next_setting(pitch_t'(1), pitch_t'(MAX_DIM), pitch_t'(257), pitch_t'(MAX_DIM));
    send_op(OP_SCROLL, 0, 0, 32'h6, 5);

    // small frame with padding
    next_setting(pitch_t'(1), pitch_t'(5), pitch_t'(4), pitch_t'(7));
    send_op(OP_FILL, 0, 0, 32'hffff_ffff, 0);
    send_op(OP_WRITE, 0, 0, 32'h0, 0);
    send_op(OP_WRITE, 4, 3, 32'ha5a5_5a5a, 0);
    send_op(OP_READ, 4, 3, 32'h0, 0);
    send_op(OP_READ, 5, 0, 32'h0, 0);
    send_op(OP_WRITE, 65535, 65535, 32'h7, 0);
    send_op(OP_SCROLL, 0, 0, 32'h11, 0);
    send_op(OP_SCROLL, 0, 0, 32'h22, 1);
    send_op(OP_READ, 4, 2, 32'h0, 0);
    send_op(OP_SCROLL, 0, 0, 32'h33, 4);
    send_op(OP_SCROLL, 0, 0, 32'h44, 65535);
    send_op(OP_READ, 0, 0, 32'h0, 0);

    // geometry extremes
    next_setting(pitch_t'(1), pitch_t'(MAX_DIM), pitch_t'(1), pitch_t'(MAX_DIM));
    send_op(OP_FILL, 0, 0, 32'h0f0f_0f0f, 0);
    send_op(OP_READ, 4095, 0, 32'h0, 0);
    next_setting(pitch_t'(1), pitch_t'(1), pitch_t'(MAX_DIM), pitch_t'(1));
    send_op(OP_WRITE, 0, 4095, 32'hc001_d00d, 0);
    send_op(OP_SCROLL, 0, 0, 32'h55, 4095);
    send_op(OP_READ, 0, 0, 32'h0, 0);
    next_setting(pitch_t'(1), pitch_t'(16), pitch_t'(64), pitch_t'(16383));
    send_op(OP_WRITE, 15, 63, 32'h8000_0001, 0);
    send_op(OP_READ, 15, 63, 32'h0, 0);
    next_setting(pitch_t'(1), pitch_t'(MAX_DIM), pitch_t'(256), pitch_t'(MAX_DIM));
    send_op(OP_WRITE, 4095, 255, 32'h7fff_fffe, 0);
    send_op(OP_READ, 4095, 255, 32'h0, 0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 3) begin
        // enable bit clear, sane geometry otherwise
        next_setting(pitch_t'($urandom_range(0, 8191) * 2), pitch_t'($urandom_range(1, 16)),
                     pitch_t'($urandom_range(1, 16)), pitch_t'($urandom_range(16, 64)));
        run_any_items(ITEMS_PER_PHASE);
      end else if (ph == 6) begin
        bad_setting();
        run_any_items(ITEMS_PER_PHASE);
      end else begin
        valid_setting();
        run_valid_items(ITEMS_PER_PHASE);
      end
    end

    cmd_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("framebuffer_pixel_engine verification clean");
    end else begin
      $display("framebuffer_pixel_engine verification failed");
    end
    $finish;
  end

endmodule
